// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the fault debounce manager.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Property on the house clock clk_i and reset rst_ni.
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_STD(lbl, prop, msg)

`endif

`endif

// ===== hw/rtl/dfdm_pkg.sv =====
// Types, codes and fault entry tables of the fault debounce manager.
`default_nettype none

package dfdm_pkg;

  // Geometry
  localparam int unsigned ENTRY_COUNT = 12;
  localparam int unsigned ENTRY_IDX_W = $clog2(ENTRY_COUNT);
  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned CHAN_COUNT  = 4;
  localparam int unsigned CHAN_W      = $clog2(CHAN_COUNT);
  localparam int unsigned CODE_W      = 24;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned STATE_W     = 2;

  // Configuration port
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [1:0] REG_DEBOUNCE_LIMIT = 2'd0;
  localparam logic [1:0] REG_OPEN_V_LIMIT   = 2'd1;
  localparam logic [1:0] REG_OPEN_I_LIMIT   = 2'd2;

  localparam logic [COUNT_W-1:0]     DEBOUNCE_LIMIT_RST = 8'd5;
  localparam logic [SAMPLE_BITS-1:0] OPEN_V_LIMIT_RST   = 10'd810;
  localparam logic [SAMPLE_BITS-1:0] OPEN_I_LIMIT_RST   = 10'd400;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_FULL = {SAMPLE_BITS{1'b1}};

  // Command codes
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // Qualifier codes
  localparam logic [STATE_W-1:0] Q_OK        = 2'd0;
  localparam logic [STATE_W-1:0] Q_PENDING   = 2'd1;
  localparam logic [STATE_W-1:0] Q_CONFIRMED = 2'd2;

  // Fault status codes
  localparam logic [STATE_W-1:0] F_NONE    = 2'd0;
  localparam logic [STATE_W-1:0] F_ACTIVE  = 2'd1;
  localparam logic [STATE_W-1:0] F_PASSIVE = 2'd2;

  // Channel codes
  localparam logic [CHAN_W-1:0] CH_IN_CURRENT  = 2'd0;
  localparam logic [CHAN_W-1:0] CH_IN_VOLTAGE  = 2'd1;
  localparam logic [CHAN_W-1:0] CH_OUT_CURRENT = 2'd2;
  localparam logic [CHAN_W-1:0] CH_OUT_VOLTAGE = 2'd3;

  // Detection condition codes
  localparam logic [1:0] C_VBAT   = 2'd0;
  localparam logic [1:0] C_GND    = 2'd1;
  localparam logic [1:0] C_OPEN_V = 2'd2;
  localparam logic [1:0] C_OPEN_I = 2'd3;

  localparam logic [ENTRY_IDX_W-1:0] LAST_ENTRY = ENTRY_IDX_W'(ENTRY_COUNT - 1);

  // Per-entry stored state
  typedef struct packed {
    logic [STATE_W-1:0]     qualify;
    logic [STATE_W-1:0]     fault;
    logic [COUNT_W-1:0]     counter;
    logic [SAMPLE_BITS-1:0] snapshot;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Result word held in the output register
  typedef struct packed {
    logic [ENTRY_IDX_W-1:0] entry_index;
    entry_t                 state;
  } result_t;

  // Fixed trouble code of each entry
  function automatic logic [CODE_W-1:0] entry_code(input logic [ENTRY_IDX_W-1:0] idx);
    logic [CODE_W-1:0] code;
    unique case (idx)
      4'd0:    code = 24'h1A0100;
      4'd1:    code = 24'h1A0101;
      4'd2:    code = 24'h1A0102;
      4'd3:    code = 24'h1A0103;
      4'd4:    code = 24'h1A0110;
      4'd5:    code = 24'h1A0111;
      4'd6:    code = 24'h1A0112;
      4'd7:    code = 24'h1A0113;
      4'd8:    code = 24'h1A0120;
      4'd9:    code = 24'h1A0121;
      4'd10:   code = 24'h1A0122;
      4'd11:   code = 24'h1A0123;
      default: code = '0;
    endcase
    return code;
  endfunction

  // Channel watched by each entry
  function automatic logic [CHAN_W-1:0] entry_chan(input logic [ENTRY_IDX_W-1:0] idx);
    logic [CHAN_W-1:0] ch;
    unique case (idx[1:0])
      2'd0:    ch = CH_IN_CURRENT;
      2'd1:    ch = CH_IN_VOLTAGE;
      2'd2:    ch = CH_OUT_CURRENT;
      default: ch = CH_OUT_VOLTAGE;
    endcase
    return ch;
  endfunction

  // Condition tested by each entry
  function automatic logic [1:0] entry_cond(input logic [ENTRY_IDX_W-1:0] idx);
    logic [1:0] cond;
    unique case (idx[3:2])
      2'd0:    cond = C_VBAT;
      2'd1:    cond = C_GND;
      default: cond = idx[0] ? C_OPEN_V : C_OPEN_I;
    endcase
    return cond;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dfdm_in_if.sv =====
// Input channel: one monitoring tick or clear command per word.
`default_nettype none

interface dfdm_in_if import dfdm_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [SAMPLE_BITS-1:0] in_current_sample;
  logic [SAMPLE_BITS-1:0] in_voltage_sample;
  logic [SAMPLE_BITS-1:0] out_current_sample;
  logic [SAMPLE_BITS-1:0] out_voltage_sample;

  modport source (
    output valid, func, in_current_sample, in_voltage_sample,
           out_current_sample, out_voltage_sample,
    input  ready
  );

  modport sink (
    input  valid, func, in_current_sample, in_voltage_sample,
           out_current_sample, out_voltage_sample,
    output ready
  );

endinterface

`default_nettype wire

// ===== hw/rtl/dfdm_out_if.sv =====
// Output channel: one fault entry status per word.
`default_nettype none

interface dfdm_out_if import dfdm_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic [ENTRY_IDX_W-1:0] entry_index;
  logic [CODE_W-1:0]      trouble_code;
  logic [STATE_W-1:0]     qualify_state;
  logic [STATE_W-1:0]     fault_state;
  logic [COUNT_W-1:0]     debounce_count;
  logic [SAMPLE_BITS-1:0] freeze_frame;
  logic                   last;

  modport source (
    output valid, entry_index, trouble_code, qualify_state, fault_state,
           debounce_count, freeze_frame, last,
    input  ready
  );

  modport sink (
    input  valid, entry_index, trouble_code, qualify_state, fault_state,
           debounce_count, freeze_frame, last,
    output ready
  );

endinterface

`default_nettype wire

// ===== hw/rtl/dfdm_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none

module dfdm_ram #(
  parameter int unsigned WIDTH = 22,
  parameter int unsigned DEPTH = 12
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dtc_fault_debounce_manager_unit.sv =====
// Top level of the fault debounce manager: config registers, entry sequencer, output.
`default_nettype none
`include "assert_macros.svh"

// Twelve fault entries (short to battery, short to ground and open circuit on
// the four converter channels) keep their debounce state in one 12 x 22 RAM.
// Each accepted word, a monitoring tick or a clear command, walks the entries
// in index order: read one entry, update it from the registered read data,
// write it back and present its status word on the output channel, twelve
// words per input with last set on entry 11. An item runs through the RAM
// reads, the final update and the return to idle before the next word is
// accepted; output stalls stop the sequencer. Entries reset to ok / never
// seen / zero through per-entry valid bits, so there is no clearing pass
// after reset. Configuration registers (APB, byte address 4 * index) must be
// written only while the block is idle; the block itself does not enforce it.
module dtc_fault_debounce_manager_unit import dfdm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready,
  // data channels
  dfdm_in_if.sink                 in_i,
  dfdm_out_if.source              out_o
);

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [COUNT_W-1:0]     deb_limit_q;
  logic [SAMPLE_BITS-1:0] ov_limit_q;
  logic [SAMPLE_BITS-1:0] oc_limit_q;
  logic                   cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_limit_q <= DEBOUNCE_LIMIT_RST;
      ov_limit_q  <= OPEN_V_LIMIT_RST;
      oc_limit_q  <= OPEN_I_LIMIT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DEBOUNCE_LIMIT: deb_limit_q <= pwdata[COUNT_W-1:0];
        REG_OPEN_V_LIMIT:   ov_limit_q  <= pwdata[SAMPLE_BITS-1:0];
        REG_OPEN_I_LIMIT:   oc_limit_q  <= pwdata[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[3:2])
      REG_DEBOUNCE_LIMIT: prdata = PDATA_W'(deb_limit_q);
      REG_OPEN_V_LIMIT:   prdata = PDATA_W'(ov_limit_q);
      REG_OPEN_I_LIMIT:   prdata = PDATA_W'(oc_limit_q);
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer and captured input word
  logic [1:0]             state_q, state_d;
  logic [ENTRY_IDX_W-1:0] rd_idx_q;
  logic [ENTRY_IDX_W-1:0] s1_idx_q;
  logic                   s1_valid_q;
  logic                   rd_vld_q;
  logic                   func_q;
  logic [SAMPLE_BITS-1:0] samp_q [CHAN_COUNT];
  logic [ENTRY_COUNT-1:0] valid_q;

  logic in_acc;
  logic adv;
  logic ram_re;
  logic ram_we;
  logic s1_done;

  result_t res_q;
  logic    out_valid_q;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  // output register free to take the update stage's word
  assign adv        = !out_valid_q || out_o.ready;
  assign ram_re     = (state_q == ST_READ) && (!s1_valid_q || adv);
  assign ram_we     = s1_valid_q && adv;
  assign s1_done    = ram_we && (s1_idx_q == LAST_ENTRY);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_READ;
      ST_READ:  if (ram_re && (rd_idx_q == LAST_ENTRY)) state_d = ST_DRAIN;
      ST_DRAIN: if (s1_done) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_idx_q   <= '0;
      s1_valid_q <= 1'b0;
      valid_q    <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        rd_idx_q <= '0;
      end else if (ram_re) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (ram_re) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (ram_we) begin
        valid_q[s1_idx_q] <= 1'b1;
      end
    end
  end

  // Payload of the captured word and the read stage
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q                 <= in_i.func;
      samp_q[CH_IN_CURRENT]  <= in_i.in_current_sample;
      samp_q[CH_IN_VOLTAGE]  <= in_i.in_voltage_sample;
      samp_q[CH_OUT_CURRENT] <= in_i.out_current_sample;
      samp_q[CH_OUT_VOLTAGE] <= in_i.out_voltage_sample;
    end
    if (ram_re) begin
      s1_idx_q <= rd_idx_q;
      rd_vld_q <= valid_q[rd_idx_q];
    end
  end

  // ---------------------------------------------------------------------------
  // Entry state memory
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             cur, nxt;

  dfdm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRY_COUNT)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_idx_q),
    .wdata_i (nxt),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Update stage: clear, or detect, debounce, qualify
  logic [SAMPLE_BITS-1:0] smp;
  logic                   hit;

  always_comb begin
    cur = rd_vld_q ? entry_t'(ram_rdata) : '0;
    smp = samp_q[entry_chan(s1_idx_q)];

    unique case (entry_cond(s1_idx_q))
      C_VBAT:   hit = (smp == SAMPLE_FULL);
      C_GND:    hit = (smp == '0);
      C_OPEN_V: hit = (smp > ov_limit_q) && (smp != SAMPLE_FULL);
      default:  hit = (smp < oc_limit_q) && (smp != '0);
    endcase

    nxt = cur;
    if (func_q == FUNC_CLEAR) begin
      nxt = '0;
    end else if (hit) begin
      if (cur.counter < deb_limit_q) nxt.counter = cur.counter + 1'b1;
      if (cur.qualify == Q_OK) nxt.qualify = Q_PENDING;
      if ((nxt.qualify == Q_PENDING) && (nxt.counter >= deb_limit_q)) begin
        nxt.qualify  = Q_CONFIRMED;
        nxt.fault    = F_ACTIVE;
        nxt.snapshot = smp;
      end
    end else if (cur.counter != '0) begin
      nxt.counter = cur.counter - 1'b1;
    end else if (cur.qualify == Q_CONFIRMED) begin
      nxt.qualify = Q_OK;
      nxt.fault   = F_PASSIVE;
    end else if (cur.qualify == Q_PENDING) begin
      nxt.qualify = Q_OK;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      res_q.entry_index <= s1_idx_q;
      res_q.state       <= nxt;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.entry_index    = res_q.entry_index;
  assign out_o.trouble_code   = entry_code(res_q.entry_index);
  assign out_o.qualify_state  = res_q.state.qualify;
  assign out_o.fault_state    = res_q.state.fault;
  assign out_o.debounce_count = res_q.state.counter;
  assign out_o.freeze_frame   = res_q.state.snapshot;
  assign out_o.last           = (res_q.entry_index == LAST_ENTRY);

  // ---------------------------------------------------------------------------
  // Assertions
  `ASSERT_STD(a_accept_empty, in_acc |-> !s1_valid_q && !ram_we, "word accepted while busy")
  `ASSERT_STD(a_no_rw_clash, (ram_we && ram_re) |-> (s1_idx_q != rd_idx_q), "entry read/write clash")
  `ASSERT_STD(a_last_idle, s1_done |=> (state_q == ST_IDLE) && out_valid_q, "last entry not closing item")
  `ASSERT_STD(a_read_order, ram_re && (state_q == ST_READ) && s1_valid_q |-> (s1_idx_q + 1'b1 == rd_idx_q), "entry order broken")

endmodule

`default_nettype wire

// ===== tb/sv/dtc_fault_debounce_manager_unit_tb.sv =====
// Self-checking testbench of the fault debounce manager: stimulus, status predictor, checker.
`timescale 1ns / 1ps

module dtc_fault_debounce_manager_unit_tb;
  import dfdm_pkg::*;

  // Stimulus classes for one channel's sample
  localparam int CLS_GND  = 0;
  localparam int CLS_BAT  = 1;
  localparam int CLS_OPEN = 2;
  localparam int CLS_GOOD = 3;
  localparam int CLS_ANY  = 4;
  localparam int CLS_EDGE = 5;

  // Unmapped register slot, writes must be ignored
  localparam logic [1:0] REG_SPARE = 2'd3;

  // Longest legal quiet spell is the sink hold plus a config phase
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int IDLE_PCT    = 38;

  typedef struct packed {
    logic                   func;
    logic [SAMPLE_BITS-1:0] i_in;
    logic [SAMPLE_BITS-1:0] v_in;
    logic [SAMPLE_BITS-1:0] i_out;
    logic [SAMPLE_BITS-1:0] v_out;
  } tick_word_t;

  typedef struct packed {
    logic [ENTRY_IDX_W-1:0] idx;
    logic [CODE_W-1:0]      code;
    logic [STATE_W-1:0]     qual;
    logic [STATE_W-1:0]     fault;
    logic [COUNT_W-1:0]     count;
    logic [SAMPLE_BITS-1:0] frame;
    logic                   last;
  } dtc_status_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  wire  [PDATA_W-1:0] prdata;
  wire                pready;

  dfdm_in_if  tick_ch ();
  dfdm_out_if status_ch ();

  dtc_fault_debounce_manager_unit i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (tick_ch),
    .out_o   (status_ch)
  );

  // Predictor copy of the registers and the entry table
  logic [COUNT_W-1:0]     lim_debounce = DEBOUNCE_LIMIT_RST;
  logic [SAMPLE_BITS-1:0] lim_open_v   = OPEN_V_LIMIT_RST;
  logic [SAMPLE_BITS-1:0] lim_open_i   = OPEN_I_LIMIT_RST;
  logic [STATE_W-1:0]     ent_qual  [ENTRY_COUNT];
  logic [STATE_W-1:0]     ent_fault [ENTRY_COUNT];
  logic [COUNT_W-1:0]     ent_count [ENTRY_COUNT];
  logic [SAMPLE_BITS-1:0] ent_frame [ENTRY_COUNT];

  tick_word_t  tick_backlog [$];
  dtc_status_t status_due [$];

  int   mismatches   = 0;
  int   quiet_cycles = 0;
  int   src_idle_pct = IDLE_PCT;
  int   snk_idle_pct = IDLE_PCT;
  int   hold_req     = 0;
  int   hold_ack     = 0;
  int   hold_left    = 0;
  logic in_taken     = 1'b0;

  // Per-channel run state of the random stimulus
  int run_cls  [CHAN_COUNT];
  int run_left [CHAN_COUNT];

  initial begin
    for (int e = 0; e < ENTRY_COUNT; e++) begin
      ent_qual[e]  = Q_OK;
      ent_fault[e] = F_NONE;
      ent_count[e] = '0;
      ent_frame[e] = '0;
    end
    for (int c = 0; c < CHAN_COUNT; c++) begin
      run_cls[c]  = CLS_ANY;
      run_left[c] = 0;
    end
  end

  always #1 clk = ~clk;

  // Apply one word to the entry table and queue the twelve status words it yields
  task automatic advance_entries(input tick_word_t w);
    logic [SAMPLE_BITS-1:0] chan_val [CHAN_COUNT];
    logic [SAMPLE_BITS-1:0] s;
    logic [1:0]             cond;
    logic                   hit;
    dtc_status_t            st;
    int                     e;
    chan_val[CH_IN_CURRENT]  = w.i_in;
    chan_val[CH_IN_VOLTAGE]  = w.v_in;
    chan_val[CH_OUT_CURRENT] = w.i_out;
    chan_val[CH_OUT_VOLTAGE] = w.v_out;
    for (e = 0; e < ENTRY_COUNT; e++) begin
      if (w.func == FUNC_CLEAR) begin
        ent_qual[e]  = Q_OK;
        ent_fault[e] = F_NONE;
        ent_count[e] = '0;
        ent_frame[e] = '0;
      end else begin
        // entries 0-3 battery, 4-7 ground, 8-11 open (even current, odd voltage)
        s = chan_val[e % CHAN_COUNT];
        if (e < 4) cond = C_VBAT;
        else if (e < 8) cond = C_GND;
        else cond = (e % 2 == 1) ? C_OPEN_V : C_OPEN_I;
        case (cond)
          C_VBAT:   hit = (s == SAMPLE_FULL);
          C_GND:    hit = (s == '0);
          C_OPEN_V: hit = (s > lim_open_v) && (s != SAMPLE_FULL);
          default:  hit = (s < lim_open_i) && (s != '0);
        endcase
        if (hit) begin
          if (ent_count[e] < lim_debounce) ent_count[e]++;
          if (ent_qual[e] == Q_OK) ent_qual[e] = Q_PENDING;
          if (ent_qual[e] == Q_PENDING && ent_count[e] >= lim_debounce) begin
            ent_qual[e]  = Q_CONFIRMED;
            ent_fault[e] = F_ACTIVE;
            ent_frame[e] = s;
          end
        end else if (ent_count[e] != '0) begin
          ent_count[e]--;
        end else if (ent_qual[e] == Q_CONFIRMED) begin
          ent_qual[e]  = Q_OK;
          ent_fault[e] = F_PASSIVE;
        end else if (ent_qual[e] == Q_PENDING) begin
          ent_qual[e] = Q_OK;
        end
      end
      st.idx   = ENTRY_IDX_W'(e);
      st.code  = 24'h1A0100 + CODE_W'(16 * (e / 4) + e % 4);
      st.qual  = ent_qual[e];
      st.fault = ent_fault[e];
      st.count = ent_count[e];
      st.frame = ent_frame[e];
      st.last  = (e == ENTRY_COUNT - 1);
      status_due.push_back(st);
    end
  endtask

  // Sample drawn from a stimulus class against the current limits
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int cls, input bit volt);
    logic [SAMPLE_BITS-1:0] v;
    case (cls)
      CLS_GND: v = '0;
      CLS_BAT: v = SAMPLE_FULL;
      CLS_OPEN: begin
        if (volt)
          v = (lim_open_v >= 1022) ? 10'd1022 :
              SAMPLE_BITS'($urandom_range(1022, lim_open_v + 1));
        else
          v = (lim_open_i <= 1) ? 10'd1 : SAMPLE_BITS'($urandom_range(lim_open_i - 1, 1));
      end
      CLS_GOOD: begin
        if (lim_open_i >= 1 && lim_open_i <= lim_open_v)
          v = SAMPLE_BITS'($urandom_range(lim_open_v, lim_open_i));
        else
          v = SAMPLE_BITS'($urandom_range(1022, 1));
      end
      CLS_EDGE: begin
        case ($urandom_range(5))
          0:       v = lim_open_v;
          1:       v = lim_open_v + 1'b1;
          2:       v = lim_open_i;
          3:       v = lim_open_i - 1'b1;
          4:       v = 10'd1;
          default: v = 10'd1022;
        endcase
      end
      default: v = SAMPLE_BITS'($urandom_range(1023));
    endcase
    return v;
  endfunction

  task automatic push_tick(input logic func, input int a, input int b, input int c,
                           input int d);
    tick_backlog.push_back({func, SAMPLE_BITS'(a), SAMPLE_BITS'(b), SAMPLE_BITS'(c),
                            SAMPLE_BITS'(d)});
  endtask

  // Random ticks: each channel holds one fault class for a run, so debounce can mature
  task automatic queue_random_ticks(input int n);
    logic [SAMPLE_BITS-1:0] smp [CHAN_COUNT];
    tick_word_t             w;
    int                     k;
    int                     c;
    int                     r;
    int                     run_cap;
    run_cap = (lim_debounce + 4 > 14) ? 14 : lim_debounce + 4;
    for (k = 0; k < n; k++) begin
      for (c = 0; c < CHAN_COUNT; c++) begin
        if (run_left[c] == 0) begin
          r = $urandom_range(99);
          if (r < 14) run_cls[c] = CLS_GND;
          else if (r < 28) run_cls[c] = CLS_BAT;
          else if (r < 50) run_cls[c] = CLS_OPEN;
          else if (r < 75) run_cls[c] = CLS_GOOD;
          else if (r < 90) run_cls[c] = CLS_ANY;
          else run_cls[c] = CLS_EDGE;
          run_left[c] = $urandom_range(run_cap, 1);
        end
        run_left[c]--;
        smp[c] = pick_sample(run_cls[c], c % 2 == 1);
      end
      w.func  = ($urandom_range(99) < 3) ? FUNC_CLEAR : FUNC_TICK;
      w.i_in  = smp[CH_IN_CURRENT];
      w.v_in  = smp[CH_IN_VOLTAGE];
      w.i_out = smp[CH_OUT_CURRENT];
      w.v_out = smp[CH_OUT_VOLTAGE];
      tick_backlog.push_back(w);
    end
  endtask

  // Test sequence waits until every queued word is sent and every status word has come back;
  // checked at the rising edge, where the driver never changes the backlog
  task automatic wait_idle();
    while (tick_backlog.size() != 0 || tick_ch.valid || status_due.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write: setup then access; the predictor copy keeps the low bits of the data
  task automatic reg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_DEBOUNCE_LIMIT: lim_debounce = val[COUNT_W-1:0];
      REG_OPEN_V_LIMIT:   lim_open_v   = val[SAMPLE_BITS-1:0];
      REG_OPEN_I_LIMIT:   lim_open_i   = val[SAMPLE_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [COUNT_W-1:0] dl, input logic [SAMPLE_BITS-1:0] ov,
                            input logic [SAMPLE_BITS-1:0] oc);
    wait_idle();
    reg_write(REG_DEBOUNCE_LIMIT, {24'($urandom), dl});
    reg_write(REG_OPEN_V_LIMIT, {22'($urandom), ov});
    reg_write(REG_OPEN_I_LIMIT, {22'($urandom), oc});
  endtask

  // Input driver: hold a word until taken, otherwise offer the next one or idle
  always @(negedge clk) begin : tick_drive
    tick_word_t nxt;
    logic       give;
    if (rst_n && (!tick_ch.valid || in_taken)) begin
      give = (tick_backlog.size() != 0) && ($urandom_range(99) >= src_idle_pct);
      if (give) begin
        nxt = tick_backlog.pop_front();
        tick_ch.valid              <= 1'b1;
        tick_ch.func               <= nxt.func;
        tick_ch.in_current_sample  <= nxt.i_in;
        tick_ch.in_voltage_sample  <= nxt.v_in;
        tick_ch.out_current_sample <= nxt.i_out;
        tick_ch.out_voltage_sample <= nxt.v_out;
      end else begin
        tick_ch.valid <= 1'b0;
      end
    end
  end

  // Output ready: random stalls, or a long hold-off on request
  always @(negedge clk) begin : status_ready
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      status_ch.ready <= 1'b0;
    end else begin
      status_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Monitor: predict on accepted input words, check accepted status words
  always @(posedge clk) begin : port_watch
    dtc_status_t got;
    dtc_status_t want;
    in_taken <= rst_n && tick_ch.valid && tick_ch.ready;
    if (rst_n) begin
      if (tick_ch.valid && tick_ch.ready)
        advance_entries({tick_ch.func, tick_ch.in_current_sample, tick_ch.in_voltage_sample,
                         tick_ch.out_current_sample, tick_ch.out_voltage_sample});
      if (status_ch.valid && status_ch.ready) begin
        got = {status_ch.entry_index, status_ch.trouble_code, status_ch.qualify_state,
               status_ch.fault_state, status_ch.debounce_count, status_ch.freeze_frame,
               status_ch.last};
        if (status_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected status word: idx %0d code %h", got.idx, got.code);
        end else begin
          want = status_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("status mismatch exp: idx %0d code %h q %0d f %0d cnt %0d frz %0d last %0b",
                       want.idx, want.code, want.qual, want.fault, want.count, want.frame,
                       want.last);
              $display("               got: idx %0d code %h q %0d f %0d cnt %0d frz %0d last %0b",
                       got.idx, got.code, got.qual, got.fault, got.count, got.frame, got.last);
            end
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk) begin : watchdog
    if (!rst_n || (tick_ch.valid && tick_ch.ready) || (status_ch.valid && status_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("dtc_fault_debounce_manager_unit_tb NOT OK");
      $finish;
    end
  end

  // Test sequence
  initial begin
    clk                        = 1'b0;
    rst_n                      = 1'b0;
    psel                       = 1'b0;
    penable                    = 1'b0;
    pwrite                     = 1'b0;
    paddr                      = '0;
    pwdata                     = '0;
    tick_ch.valid              = 1'b0;
    tick_ch.func               = FUNC_TICK;
    tick_ch.in_current_sample  = '0;
    tick_ch.in_voltage_sample  = '0;
    tick_ch.out_current_sample = '0;
    tick_ch.out_voltage_sample = '0;
    status_ch.ready            = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed, reset limits: confirm on shorts, decay to passive, open boundaries, clear
    repeat (6) push_tick(FUNC_TICK, 0, 1023, 0, 1023);
    repeat (6) push_tick(FUNC_TICK, 600, 600, 600, 600);
    push_tick(FUNC_TICK, 1, 811, 399, 1022);
    push_tick(FUNC_TICK, 400, 810, 1023, 0);
    push_tick(FUNC_CLEAR, 1023, 0, 1023, 0);
    push_tick(FUNC_TICK, 1022, 1, 512, 1);
    push_tick(FUNC_TICK, 0, 0, 0, 0);
    repeat (2) push_tick(FUNC_TICK, 1023, 1023, 1023, 1023);
    push_tick(FUNC_CLEAR, 0, 0, 0, 0);

    // Fastest confirm, every non-extreme sample is open
    set_limits(8'd1, 10'd0, 10'd1023);
    queue_random_ticks(25);

    // Zero debounce limit, open detection disabled; spare slot write is ignored
    set_limits(8'd0, 10'd1023, 10'd0);
    reg_write(REG_SPARE, $urandom);
    queue_random_ticks(30);

    // Long debounce without any idling, ending with counters parked high
    set_limits(8'd12, 10'd700, 10'd300);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    queue_random_ticks(30);
    repeat (8) push_tick(FUNC_TICK, 0, 1023, 0, 1023);
    wait_idle();
    src_idle_pct = IDLE_PCT;
    snk_idle_pct = IDLE_PCT;

    // Limit dropped below the parked counters; sink holds off while words keep coming
    set_limits(8'd2, 10'd810, 10'd400);
    hold_req++;
    repeat (3) push_tick(FUNC_TICK, 0, 1023, 0, 1023);
    queue_random_ticks(25);

    // Maximum debounce limit
    set_limits(8'd255, 10'd600, 10'd200);
    queue_random_ticks(30);

    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && status_due.size() == 0)
      $display("dtc_fault_debounce_manager_unit_tb OK");
    else
      $display("dtc_fault_debounce_manager_unit_tb NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dfdm_pkg.sv
hw/rtl/dfdm_in_if.sv
hw/rtl/dfdm_out_if.sv
hw/rtl/dfdm_ram.sv
hw/rtl/dtc_fault_debounce_manager_unit.sv
tb/sv/dtc_fault_debounce_manager_unit_tb.sv
